// File: hdl/hrnkd_pkg.sv
// Shared types and constants for the keyboard report new-key detector.
package hrnkd_pkg;

   localparam int KEY_SLOTS = 6;
   localparam int CODE_W    = 8;
   localparam int MOD_W     = 8;

   localparam logic [CODE_W-1:0] CODE_EMPTY    = CODE_W'(0);
   localparam logic [CODE_W-1:0] CODE_ROLLOVER = CODE_W'(1);

   typedef logic [CODE_W-1:0]                 code_type;
   typedef logic [KEY_SLOTS-1:0][CODE_W-1:0]  slot_array_type;
   typedef logic [KEY_SLOTS-1:0]              slot_mask_type;

   typedef struct packed {
      logic [MOD_W-1:0] mods;
      slot_array_type   slots;
   } report_type;

   // Handshake between the detect stage and the event serializer.
   typedef struct packed {
      logic load;      // report moves from the input register this cycle
   } emit_ctrl_type;

endpackage

// File: hdl/hrnkd_detect.sv
// Held-code set, rollover flag and new-press mask for one report.
module hrnkd_detect (
   input  logic                    clock,
   input  logic                    reset,
   input  hrnkd_pkg::report_type   report,
   input  logic                    advance,
   output hrnkd_pkg::slot_mask_type new_mask
);

   hrnkd_pkg::slot_array_type held_codes_ff, held_codes_in;
   logic                      rollover_error_ff, rollover_error_in;
   logic                      all_zero, all_one;

   always_comb begin
      all_zero = 1'b1;
      all_one  = 1'b1;
      for (int i = 0; i < hrnkd_pkg::KEY_SLOTS; i++) begin
         if (report.slots[i] != hrnkd_pkg::CODE_EMPTY)    all_zero = 1'b0;
         if (report.slots[i] != hrnkd_pkg::CODE_ROLLOVER) all_one  = 1'b0;
      end
   end

   always_comb begin
      new_mask          = '0;
      held_codes_in     = held_codes_ff;
      rollover_error_in = rollover_error_ff;
      if (rollover_error_ff && !all_zero) begin
         // drop the report, keep the state
      end else if (all_one) begin
         rollover_error_in = 1'b1;
         held_codes_in     = '0;
      end else begin
         rollover_error_in = 1'b0;
         held_codes_in     = report.slots;
         for (int i = 0; i < hrnkd_pkg::KEY_SLOTS; i++) begin
            new_mask[i] = (report.slots[i] != hrnkd_pkg::CODE_EMPTY);
            for (int j = 0; j < hrnkd_pkg::KEY_SLOTS; j++) begin
               if (held_codes_ff[j] == report.slots[i]) new_mask[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_codes_ff     <= '0;
         rollover_error_ff <= 1'b0;
      end else if (advance) begin
         held_codes_ff     <= held_codes_in;
         rollover_error_ff <= rollover_error_in;
      end
   end

endmodule

// File: hdl/hrnkd_emit.sv
// Event serializer: one press event per beat, lowest slot first.
module hrnkd_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  hrnkd_pkg::emit_ctrl_type  ctrl_in,
   output logic                      free,
   input  hrnkd_pkg::report_type     report,
   input  hrnkd_pkg::slot_mask_type  new_mask,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [hrnkd_pkg::MOD_W-1:0] rsp_event_modifiers,
   output hrnkd_pkg::code_type       rsp_pressed_code,
   output logic                      rsp_last_of_run
);

   hrnkd_pkg::slot_mask_type  mask_ff, mask_in;
   hrnkd_pkg::slot_mask_type  mask_rest;
   hrnkd_pkg::report_type     report_ff;
   hrnkd_pkg::code_type       sel_code;

   assign mask_rest = mask_ff & (mask_ff - hrnkd_pkg::slot_mask_type'(1));

   always_comb begin
      sel_code = hrnkd_pkg::CODE_EMPTY;
      for (int i = hrnkd_pkg::KEY_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) sel_code = report_ff.slots[i];
      end
   end

   assign rsp_valid           = (mask_ff != '0);
   assign rsp_last_of_run     = (mask_rest == '0);
   assign rsp_pressed_code    = sel_code;
   assign rsp_event_modifiers = report_ff.mods;
   assign free                = !rsp_valid || (rsp_last_of_run && rsp_ready);

   always_comb begin
      mask_in = mask_ff;
      if (ctrl_in.load)                mask_in = new_mask;
      else if (rsp_valid && rsp_ready) mask_in = mask_rest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_in.load) begin
         report_ff <= report;
      end
   end

endmodule

// File: hdl/hid_report_new_key_detector.sv
// Top level of the keyboard boot report new-key detector.
//
//   channel | direction | beat carries                                   | handshake
//   req_    | in        | modifier byte, six key slots (one report)      | valid/ready
//   rsp_    | out       | modifiers, pressed code, last-of-run flag      | valid/ready
//
// A report lands in the input register, is compared against the held set
// combinationally and moves to the serializer, which shows one press event
// per cycle while rsp_ready is high. A report with n new codes holds the
// input side until its last event is taken, set by the single result port.
// Reset clears the held set, the rollover flag and all valid state.
// A stall on rsp_ready holds the current event and, behind it, the input.
module hid_report_new_key_detector (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_modifier_bits,
   input  logic [7:0] req_key_slot_0,
   input  logic [7:0] req_key_slot_1,
   input  logic [7:0] req_key_slot_2,
   input  logic [7:0] req_key_slot_3,
   input  logic [7:0] req_key_slot_4,
   input  logic [7:0] req_key_slot_5,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_event_modifiers,
   output logic [7:0] rsp_pressed_code,
   output logic       rsp_last_of_run
);

   hrnkd_pkg::report_type     req_report;
   hrnkd_pkg::report_type     report_ff;
   logic                      in_valid_ff, in_valid_in;
   hrnkd_pkg::slot_mask_type  new_mask;
   hrnkd_pkg::emit_ctrl_type  emit_ctrl;
   logic                      emit_free;

   // Pack the report ports; slot i sits at index i.
   always_comb begin
      req_report.mods     = req_modifier_bits;
      req_report.slots[0] = req_key_slot_0;
      req_report.slots[1] = req_key_slot_1;
      req_report.slots[2] = req_key_slot_2;
      req_report.slots[3] = req_key_slot_3;
      req_report.slots[4] = req_key_slot_4;
      req_report.slots[5] = req_key_slot_5;
   end

   // Advance the held report whenever the serializer can take it; a report
   // with no new code passes through without occupying the serializer.
   assign emit_ctrl.load = in_valid_ff && emit_free;
   assign req_ready      = !in_valid_ff || emit_ctrl.load;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) in_valid_in = 1'b1;
      else if (emit_ctrl.load)    in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the payload on each accepted beat.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         report_ff <= req_report;
      end
   end

   hrnkd_detect u_detect (
      .clock    (clock),
      .reset    (reset),
      .report   (report_ff),
      .advance  (emit_ctrl.load),
      .new_mask (new_mask)
   );

   hrnkd_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .ctrl_in             (emit_ctrl),
      .free                (emit_free),
      .report              (report_ff),
      .new_mask            (new_mask),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_modifiers (rsp_event_modifiers),
      .rsp_pressed_code    (rsp_pressed_code),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule

// File: hdl/hrnkd_checker.sv
// Port-level assertions for the new-key detector, bound to the top level.
module hrnkd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_event_modifiers,
   input logic [7:0] rsp_pressed_code,
   input logic       rsp_last_of_run
);

   // Never emit an empty slot code.
   a_code_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pressed_code != 8'd0)
      else $error("press event with empty code");

   // Events of one report follow back to back until the last one.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("run of press events broken before its last beat");

   // All events of one run carry the same modifier byte.
   a_run_mods: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
         rsp_event_modifiers == $past(rsp_event_modifiers))
      else $error("modifiers changed inside one run");

   // Hold a stalled beat.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pressed_code)
         && $stable(rsp_last_of_run) && $stable(rsp_event_modifiers))
      else $error("stalled press event changed");

endmodule

bind hid_report_new_key_detector hrnkd_checker u_hrnkd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_event_modifiers (rsp_event_modifiers),
   .rsp_pressed_code    (rsp_pressed_code),
   .rsp_last_of_run     (rsp_last_of_run)
);
